[rtl/indexed_min_heap_defines.svh]
// assertion macros for the port checker in imh_checker.sv
`ifndef INDEXED_MIN_HEAP_DEFINES_SVH
`define INDEXED_MIN_HEAP_DEFINES_SVH

// clocked implication, disabled while reset is asserted
`define IMH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/imh_pkg.sv]
// ----------------------------------------------------------------------------
// imh_pkg
// types and constants of the indexed min-heap
// ----------------------------------------------------------------------------
package imh_pkg;
	localparam int HEAP_SIZE = 1024;
	localparam int KEY_BITS = 32;
	localparam int SLOT_W = $clog2(HEAP_SIZE);
	localparam int CNT_W = SLOT_W + 1;
	localparam int ID_W = 10;
	localparam int KEY_W = 32;
	localparam int CNT_OUT_W = 11;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_UPDATE = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [ID_W-1:0]  entry_id;
		logic [KEY_W-1:0] key;
	} heap_in_t;

	typedef struct packed {
		logic [ID_W-1:0]      top_id;
		logic [KEY_W-1:0]     top_key;
		logic [CNT_OUT_W-1:0] entry_count;
		logic                 is_empty;
		logic                 op_error;
	} heap_out_t;

	// one heap slot: key and owning id
	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [ID_W-1:0]     id;
	} slot_t;

	localparam int SLOT_BITS = KEY_BITS + ID_W;
endpackage

[rtl/indexed_min_heap.sv]
// Indexed binary min-heap. Each accepted transaction (insert, update, remove)
// yields exactly one result with the top id and key, the count and an error
// flag. Slots live in one single-port ram (key and id), and the id-to-slot map
// with a presence bit per id lives in a second one. After reset a clearing pass
// empties the map before the first transaction is taken. A rejected transaction
// skips the heap work; otherwise the entry moves one level per swap, up or
// down, through the single port of the slot ram, for up to 1024 entries. One
// transaction is worked at a time; a finished result waits in the output
// register while the next transaction is taken, and the work stalls in its
// last step while an older result is still waiting.
module indexed_min_heap
	import imh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  heap_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output heap_out_t out_data
);
	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_POS_RD, ST_POS_WAIT, ST_START,
		ST_LAST_RD, ST_LAST_WAIT, ST_MOVE_WR,
		ST_CUR_RD, ST_CUR_WAIT, ST_DECIDE,
		ST_UP_RD, ST_UP_WAIT, ST_UP_CMP,
		ST_DN_LRD, ST_DN_RRD, ST_DN_RWAIT, ST_DN_CMP,
		ST_SWAP_A, ST_SWAP_B, ST_MAP_A, ST_MAP_B,
		ST_TOP_RD, ST_TOP_WAIT, ST_DONE
	} state_t;

	// position map entry: presence and slot of one id
	typedef struct packed {
		logic              present;
		logic [SLOT_W-1:0] slot;
	} pos_t;

	state_t state_q;
	logic [1:0] mode_q;
	logic [ID_W-1:0] id_q;
	logic [KEY_BITS-1:0] key_q, old_key_q;
	logic [CNT_W-1:0] count_q;
	logic [SLOT_W-1:0] cur_q, oth_q;
	slot_t cur_slot_q, oth_slot_q, left_slot_q;
	logic right_ok_q, up_q;
	logic [SLOT_W-1:0] clr_q;
	logic err_q;
	logic out_valid_q;
	heap_out_t out_q;

	// slot ram port
	logic s_we;
	logic [SLOT_W-1:0] s_addr;
	slot_t s_wdata, s_rdata;
	// position ram port
	logic p_we;
	logic [SLOT_W-1:0] p_addr;
	pos_t p_wdata, p_rdata;

	imh_ram #(.WIDTH(SLOT_BITS), .DEPTH(HEAP_SIZE)) u_slot_ram (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
	);
	imh_ram #(.WIDTH($bits(pos_t)), .DEPTH(HEAP_SIZE)) u_pos_ram (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
	);

	logic [SLOT_W-1:0] id_idx;
	logic valid_id, present;
	logic [CNT_W-1:0] left_w, right_w;
	logic [SLOT_W-1:0] last_slot;
	logic out_load;

	assign id_idx = id_q[SLOT_W-1:0];
	assign valid_id = {{(CNT_W-ID_W){1'b0}}, id_q} < CNT_W'(HEAP_SIZE);
	assign present = valid_id && p_rdata.present;
	assign left_w = {cur_q, 1'b1};
	assign right_w = left_w + CNT_W'(1);
	assign last_slot = SLOT_W'(count_q - CNT_W'(1));
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		s_we = 1'b0;
		s_addr = cur_q;
		s_wdata = cur_slot_q;
		p_we = 1'b0;
		p_addr = id_idx;
		p_wdata = '{present: 1'b1, slot: cur_q};
		unique case (state_q)
			ST_CLEAR: begin
				p_we = 1'b1;
				p_addr = clr_q;
				p_wdata = '0;
			end
			ST_START: begin
				if (mode_q == MODE_INSERT) begin
					s_we = 1'b1;
					s_wdata = '{key: key_q, id: id_q};
					p_we = 1'b1;
				end else if (mode_q == MODE_REMOVE) begin
					p_we = 1'b1;
					p_wdata = '0;
				end
			end
			ST_LAST_RD: s_addr = SLOT_W'(count_q);
			ST_MOVE_WR: begin
				s_we = 1'b1;
				s_wdata = oth_slot_q;
				p_we = 1'b1;
				p_addr = oth_slot_q.id[SLOT_W-1:0];
			end
			ST_UP_RD: s_addr = oth_q;
			ST_DN_LRD: s_addr = left_w[SLOT_W-1:0];
			ST_DN_RRD: s_addr = right_w[SLOT_W-1:0];
			ST_SWAP_A: begin
				s_we = 1'b1;
				s_addr = cur_q;
				s_wdata = oth_slot_q;
			end
			ST_SWAP_B: begin
				s_we = 1'b1;
				s_addr = oth_q;
				s_wdata = cur_slot_q;
			end
			ST_MAP_A: begin
				p_we = 1'b1;
				p_addr = oth_slot_q.id[SLOT_W-1:0];
				p_wdata = '{present: 1'b1, slot: cur_q};
			end
			ST_MAP_B: begin
				p_we = 1'b1;
				p_addr = cur_slot_q.id[SLOT_W-1:0];
				p_wdata = '{present: 1'b1, slot: oth_q};
			end
			// top slot stays addressed until the result is loaded
			ST_TOP_RD, ST_TOP_WAIT, ST_DONE: s_addr = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == SLOT_W'(HEAP_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						mode_q <= in_data.mode;
						id_q <= in_data.entry_id;
						key_q <= in_data.key[KEY_BITS-1:0];
						err_q <= 1'b0;
						state_q <= ST_POS_RD;
					end
				end
				ST_POS_RD: state_q <= ST_POS_WAIT;
				ST_POS_WAIT: begin
					priority if (mode_q == MODE_INSERT && valid_id && !present
							&& count_q != CNT_W'(HEAP_SIZE)) begin
						cur_q <= SLOT_W'(count_q);
						state_q <= ST_START;
					end else if ((mode_q == MODE_UPDATE || mode_q == MODE_REMOVE)
							&& present) begin
						cur_q <= p_rdata.slot;
						state_q <= ST_START;
					end else begin
						err_q <= 1'b1;
						state_q <= ST_TOP_RD;
					end
				end
				ST_START: begin
					unique case (mode_q)
						MODE_INSERT: begin
							count_q <= count_q + CNT_W'(1);
							cur_slot_q <= '{key: key_q, id: id_q};
							up_q <= 1'b1;
							state_q <= ST_DECIDE;
						end
						default: state_q <= ST_CUR_RD;
					endcase
				end
				ST_CUR_RD: state_q <= ST_CUR_WAIT;
				ST_CUR_WAIT: begin
					old_key_q <= s_rdata.key;
					if (mode_q == MODE_UPDATE) begin
						cur_slot_q <= '{key: key_q, id: s_rdata.id};
						up_q <= key_q < s_rdata.key;
						state_q <= ST_SWAP_B;
						oth_q <= cur_q;
					end else begin
						count_q <= count_q - CNT_W'(1);
						if (cur_q == last_slot) begin
							state_q <= ST_TOP_RD;
						end else begin
							state_q <= ST_LAST_RD;
						end
					end
				end
				ST_LAST_RD: state_q <= ST_LAST_WAIT;
				ST_LAST_WAIT: begin
					oth_slot_q <= s_rdata;
					cur_slot_q <= s_rdata;
					up_q <= s_rdata.key < old_key_q;
					state_q <= ST_MOVE_WR;
				end
				ST_MOVE_WR: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					if (up_q) begin
						if (cur_q == '0) begin
							state_q <= ST_TOP_RD;
						end else begin
							oth_q <= SLOT_W'((cur_q - SLOT_W'(1)) >> 1);
							state_q <= ST_UP_RD;
						end
					end else if (left_w >= count_q) begin
						state_q <= ST_TOP_RD;
					end else begin
						right_ok_q <= right_w < count_q;
						state_q <= ST_DN_LRD;
					end
				end
				ST_UP_RD: state_q <= ST_UP_WAIT;
				ST_UP_WAIT: begin
					oth_slot_q <= s_rdata;
					state_q <= ST_UP_CMP;
				end
				ST_UP_CMP: begin
					if (oth_slot_q.key > cur_slot_q.key) begin
						state_q <= ST_SWAP_A;
					end else begin
						state_q <= ST_TOP_RD;
					end
				end
				ST_DN_LRD: state_q <= ST_DN_RRD;
				ST_DN_RRD: begin
					// left child arrives while the right one is addressed
					left_slot_q <= s_rdata;
					oth_slot_q <= s_rdata;
					oth_q <= left_w[SLOT_W-1:0];
					state_q <= ST_DN_RWAIT;
				end
				ST_DN_RWAIT: begin
					// take right only when strictly smaller than left
					if (right_ok_q && s_rdata.key < left_slot_q.key) begin
						oth_slot_q <= s_rdata;
						oth_q <= right_w[SLOT_W-1:0];
					end
					state_q <= ST_DN_CMP;
				end
				ST_DN_CMP: begin
					if (oth_slot_q.key < cur_slot_q.key) begin
						state_q <= ST_SWAP_A;
					end else begin
						state_q <= ST_TOP_RD;
					end
				end
				ST_SWAP_A: state_q <= ST_SWAP_B;
				ST_SWAP_B: begin
					// update entry writes its new key in place (oth_q == cur_q)
					if (oth_q == cur_q) begin
						state_q <= ST_DECIDE;
					end else begin
						state_q <= ST_MAP_A;
					end
				end
				ST_MAP_A: state_q <= ST_MAP_B;
				ST_MAP_B: begin
					cur_q <= oth_q;
					state_q <= ST_DECIDE;
				end
				ST_TOP_RD: state_q <= ST_TOP_WAIT;
				ST_TOP_WAIT: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load) begin
						if (count_q == '0) begin
							out_q.top_id <= '0;
							out_q.top_key <= '0;
						end else begin
							out_q.top_id <= s_rdata.id;
							out_q.top_key <= KEY_W'(s_rdata.key);
						end
						out_q.entry_count <= CNT_OUT_W'(count_q);
						out_q.is_empty <= count_q == '0;
						out_q.op_error <= err_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[rtl/imh_ram.sv]
// ----------------------------------------------------------------------------
// imh_ram
// single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module imh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[rtl/imh_checker.sv]
// ----------------------------------------------------------------------------
// imh_checker
// port-level checks of the indexed min-heap, bound to the top level
// ----------------------------------------------------------------------------
`include "indexed_min_heap_defines.svh"

module imh_checker
	import imh_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input heap_in_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input heap_out_t out_data
);
	`IMH_ASSERT_IMPL(a_empty_flag, clk, arst_n, out_valid, out_data.is_empty == (out_data.entry_count == '0), "is_empty disagrees with count")
	`IMH_ASSERT_IMPL(a_empty_top, clk, arst_n, out_valid && out_data.is_empty, out_data.top_key == '0 && out_data.top_id == '0, "empty heap shows a top")
	`IMH_ASSERT_IMPL(a_count_max, clk, arst_n, out_valid, out_data.entry_count <= CNT_OUT_W'(HEAP_SIZE), "count above capacity")
	`IMH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed")
	`IMH_ASSERT_NEXT(a_one_result, clk, arst_n, in_valid && in_ready, !in_ready, "second transaction taken while busy")
endmodule

bind indexed_min_heap imh_checker u_imh_checker (.*);

[sim/indexed_min_heap_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_min_heap_checker
// watches both channels of the indexed min-heap, keeps a software copy of the
// heap and its id map, and compares every result with the expected one
// ----------------------------------------------------------------------------
module indexed_min_heap_checker
	import imh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  heap_in_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  heap_out_t out_data,
	output int        fail_count,
	output int        pending
);
	logic [KEY_W-1:0] hp_key [HEAP_SIZE];
	logic [ID_W-1:0]  hp_id [HEAP_SIZE];
	int               id_pos [HEAP_SIZE];
	bit               id_live [HEAP_SIZE];
	int               hp_count;
	heap_out_t        expected_results[$];

	function automatic void swap_slots(int a, int b);
		logic [KEY_W-1:0] k;
		logic [ID_W-1:0]  d;
		k = hp_key[a];
		d = hp_id[a];
		hp_key[a] = hp_key[b];
		hp_id[a] = hp_id[b];
		hp_key[b] = k;
		hp_id[b] = d;
		id_pos[hp_id[a]] = a;
		id_pos[hp_id[b]] = b;
	endfunction

	function automatic void bubble_up(int s);
		int p;
		while (s > 0) begin
			p = (s - 1) / 2;
			if (hp_key[p] <= hp_key[s])
				break;
			swap_slots(p, s);
			s = p;
		end
	endfunction

	function automatic void bubble_down(int s);
		int l;
		int pick;
		forever begin
			l = 2 * s + 1;
			if (l >= hp_count)
				break;
			pick = l;
			if (l + 1 < hp_count && hp_key[l + 1] < hp_key[l])
				pick = l + 1;
			if (hp_key[pick] >= hp_key[s])
				break;
			swap_slots(pick, s);
			s = pick;
		end
	endfunction

	function automatic heap_out_t apply_op(heap_in_t t);
		heap_out_t        r;
		int               id;
		int               s;
		int               last;
		logic [KEY_W-1:0] old;
		bit               err;
		id = t.entry_id;
		err = 0;
		case (mode_t'(t.mode))
			MODE_INSERT: begin
				if (id_live[id] || hp_count >= HEAP_SIZE) begin
					err = 1;
				end else begin
					s = hp_count;
					hp_key[s] = t.key;
					hp_id[s] = id;
					id_pos[id] = s;
					id_live[id] = 1;
					hp_count = s + 1;
					bubble_up(s);
				end
			end
			MODE_UPDATE: begin
				if (!id_live[id]) begin
					err = 1;
				end else begin
					s = id_pos[id];
					old = hp_key[s];
					hp_key[s] = t.key;
					if (t.key < old)
						bubble_up(s);
					else
						bubble_down(s);
				end
			end
			MODE_REMOVE: begin
				if (!id_live[id]) begin
					err = 1;
				end else begin
					s = id_pos[id];
					last = hp_count - 1;
					old = hp_key[s];
					id_live[id] = 0;
					hp_count = last;
					// hole is refilled from the last slot unless it was the last slot
					if (s != last) begin
						hp_key[s] = hp_key[last];
						hp_id[s] = hp_id[last];
						id_pos[hp_id[s]] = s;
						if (hp_key[s] < old)
							bubble_up(s);
						else
							bubble_down(s);
					end
				end
			end
			default: err = 1;
		endcase
		r.top_id = hp_count > 0 ? hp_id[0] : '0;
		r.top_key = hp_count > 0 ? hp_key[0] : '0;
		r.entry_count = CNT_OUT_W'(hp_count);
		r.is_empty = hp_count == 0;
		r.op_error = err;
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		heap_out_t exp_r;
		if (!arst_n) begin
			hp_count = 0;
			fail_count <= 0;
			for (int i = 0; i < HEAP_SIZE; i++)
				id_live[i] = 0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(apply_op(in_data));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result transaction %p", out_data);
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r !== out_data) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("result mismatch: expected %p got %p", exp_r, out_data);
					end
				end
			end
		end
	end
endmodule

[sim/tb_indexed_min_heap.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_min_heap
// drives insert, update, remove and unused-mode transactions into the indexed
// min-heap with directed corner cases, random traffic, a final drain, and random
// idling on both channels; the checker module judges the results
// ----------------------------------------------------------------------------
module tb_indexed_min_heap;
	import imh_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	heap_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	heap_out_t out_data;
	int        fail_count;
	int        pending;

	int        send_idle_pct;
	int        recv_idle_pct;
	bit        hold_off;
	bit        live [HEAP_SIZE];
	int        live_ids[$];

	indexed_min_heap uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	indexed_min_heap_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// tracks which ids the stimulus believes are held, to aim ops at them
	function automatic void note_op(mode_t m, int id);
		if (m == MODE_INSERT && !live[id] && live_ids.size() < HEAP_SIZE) begin
			live[id] = 1;
			live_ids.push_back(id);
		end else if (m == MODE_REMOVE && live[id]) begin
			live[id] = 0;
			foreach (live_ids[i])
				if (live_ids[i] == id) begin
					live_ids.delete(i);
					break;
				end
		end
	endfunction

	task automatic send_op(mode_t m, int id, logic [KEY_W-1:0] k);
		bit rdy;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{mode: m, entry_id: id[ID_W-1:0], key: k};
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
		note_op(m, id);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return KEY_W'($urandom_range(15));
			default: return $urandom;
		endcase
	endfunction

	task automatic random_ops(int n);
		int    id;
		mode_t m;
		int    r;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 40) m = MODE_INSERT;
			else if (r < 70) m = MODE_UPDATE;
			else if (r < 95) m = MODE_REMOVE;
			else m = MODE_NONE;
			if (m != MODE_INSERT && live_ids.size() > 0 && $urandom_range(9) < 8)
				id = live_ids[$urandom_range(live_ids.size() - 1)];
			else if ($urandom_range(9) < 7)
				id = $urandom_range(63);
			else
				id = $urandom_range(HEAP_SIZE - 1);
			send_op(m, id, pick_key());
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	initial begin
		int n;
		in_valid = 0;
		in_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed corner cases
		send_op(MODE_REMOVE, 5, 32'h0);          // remove from empty heap
		send_op(MODE_UPDATE, 5, 32'h10);         // update of absent id
		send_op(MODE_INSERT, 0, '0);
		send_op(MODE_INSERT, 1023, '1);
		send_op(MODE_INSERT, 0, 32'h5);          // duplicate id
		send_op(MODE_INSERT, 512, 32'h8000_0000);
		send_op(MODE_INSERT, 341, 32'h5555_5555);
		send_op(MODE_INSERT, 682, 32'haaaa_aaaa);
		send_op(MODE_INSERT, 7, 32'h8000_0000);  // tie with a parent
		send_op(MODE_UPDATE, 1023, 32'h0);       // decrease, sift up to a tie with the top
		send_op(MODE_UPDATE, 0, '1);             // increase, sift down
		send_op(MODE_UPDATE, 512, 32'h8000_0000);// same key
		send_op(MODE_NONE, 512, 32'h1);          // unused mode
		send_op(MODE_REMOVE, 7, 32'h0);          // last slot
		send_op(MODE_REMOVE, 1023, 32'h0);       // top, resift down
		send_op(MODE_REMOVE, 1023, 32'h0);       // already gone
		send_op(MODE_INSERT, 100, 32'h1);
		send_op(MODE_INSERT, 101, 32'h1);
		send_op(MODE_REMOVE, 512, 32'h0);        // last slot
		while (live_ids.size() > 0)
			send_op(MODE_REMOVE, live_ids[0], 32'h0);

		// random traffic across idling phases
		random_ops(120);
		send_idle_pct = 58;
		random_ops(120);
		send_idle_pct = 0;
		recv_idle_pct = 58;
		hold_off = 1;
		random_ops(120);
		send_idle_pct = 8;
		recv_idle_pct = 8;
		random_ops(120);

		// drain whatever is left in random order
		send_idle_pct = 0;
		recv_idle_pct = 0;
		n = 0;
		while (live_ids.size() > 0) begin
			n = $urandom_range(live_ids.size() - 1);
			send_op(MODE_REMOVE, live_ids[n], 32'h0);
		end

		in_valid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
